// File: rtl/pte_pkg.sv
// Shared types and constants for the periodic timer event scheduler.
// No dependencies.
package pte_pkg;

    localparam int SLOTS      = 16;
    localparam int TIME_BITS  = 48;
    localparam int MAX_RES    = 16;
    localparam int DELAY_BITS = 24;
    localparam int TAG_BITS   = 16;
    localparam int QDEPTH     = 2;
    localparam int IDX_BITS   = $clog2(SLOTS);
    localparam int CNT_BITS   = $clog2(MAX_RES + 1);
    localparam int QPTR_BITS  = $clog2(QDEPTH);
    localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_TICK         = 2'd0,
        OP_ADD_ONCE     = 2'd1,
        OP_ADD_PERIODIC = 2'd2,
        OP_NONE         = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_FIRED  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic                  is_tick;
        logic                  periodic;
        logic [DELAY_BITS-1:0] delay;
        logic [DELAY_BITS-1:0] period;
        logic [TAG_BITS-1:0]   tag;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic pop;
    } q_ctl_t;

endpackage

// File: rtl/pte_ifs.sv
// Handshake channels of the scheduler: command in, response out.
// No dependencies.
interface pte_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [23:0] delay;
    logic [23:0] period;
    logic [15:0] task_tag;

    modport source (output valid, op, delay, period, task_tag, input ready);
    modport sink   (input valid, op, delay, period, task_tag, output ready);
endinterface

interface pte_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] fired_tag;
    logic        last;

    modport source (output valid, kind, fired_tag, last, input ready);
    modport sink   (input valid, kind, fired_tag, last, output ready);
endinterface

// File: rtl/pte_cmd_fifo.sv
// Short command queue between front and back end.
// Depends on pte_pkg.
module pte_cmd_fifo
    import pte_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  cmd_t   push_data,
    output logic   full,
    input  q_ctl_t ctl_in,
    output logic   head_valid,
    output cmd_t   head_data
);

    cmd_t                 mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_pop;

    assign full       = (count_reg == QCNT_BITS'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_pop     = ctl_in.pop && ctl_in.valid && head_valid;

    always_ff @(posedge clk) begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_BITS'(push && !full) - QCNT_BITS'(do_pop);
        end
    end

endmodule

// File: rtl/pte_front.sv
// Front end: accepts command beats, drops OP_NONE beats, normalizes period.
// Depends on pte_pkg, pte_ifs.
module pte_front
    import pte_pkg::*;
(
    pte_cmd_if.sink cmd,
    input  logic    q_full,
    output logic    push,
    output cmd_t    push_data
);

    op_t op;

    assign op        = op_t'(cmd.op);
    assign cmd.ready = !q_full;

    always_comb begin
        push_data.is_tick  = 1'b0;
        push_data.periodic = 1'b0;
        push_data.delay    = cmd.delay;
        push_data.period   = (cmd.period == '0) ? DELAY_BITS'(1) : cmd.period;
        push_data.tag      = cmd.task_tag;
        push               = 1'b0;
        unique case (op)
            OP_TICK:
            begin
                push_data.is_tick = 1'b1;
                push              = cmd.valid && !q_full;
            end
            OP_ADD_ONCE:
            begin
                push = cmd.valid && !q_full;
            end
            OP_ADD_PERIODIC:
            begin
                push_data.periodic = 1'b1;
                push               = cmd.valid && !q_full;
            end
            OP_NONE:
            begin
                push = 1'b0;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/pte_back.sv
// Back end: timer table, slot scan, firing and response register.
// Depends on pte_pkg, pte_ifs.
module pte_back
    import pte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cmd_t      head_data,
    output q_ctl_t    q_ctl,
    pte_rsp_if.source rsp
);

    state_t                state_reg, state_next;
    logic [TIME_BITS-1:0]  now_reg;
    logic [SLOTS-1:0]      slot_valid_reg;
    logic [TIME_BITS-1:0]  slot_due_reg [SLOTS];
    logic                  slot_periodic_reg [SLOTS];
    logic [DELAY_BITS-1:0] slot_period_reg [SLOTS];
    logic [TAG_BITS-1:0]   slot_tag_reg [SLOTS];

    logic [IDX_BITS-1:0]   idx_reg;
    logic                  best_hit_reg;
    logic [TIME_BITS-1:0]  best_lag_reg;
    logic [IDX_BITS-1:0]   best_idx_reg;
    logic [TIME_BITS-1:0]  best_due_reg;
    logic                  best_periodic_reg;
    logic [DELAY_BITS-1:0] best_period_reg;
    logic [TAG_BITS-1:0]   best_tag_reg;
    logic                  pend_reg;
    logic [TAG_BITS-1:0]   pend_tag_reg;
    logic [CNT_BITS-1:0]   n_reg;

    logic                  out_valid_reg;
    logic [1:0]            out_kind_reg;
    logic [TAG_BITS-1:0]   out_tag_reg;
    logic                  out_last_reg;

    logic                  can_load, load, pop, start_tick, do_add, take, scan_step;
    logic [1:0]            load_kind;
    logic [TAG_BITS-1:0]   load_tag;
    logic                  load_last;
    logic [TIME_BITS-1:0]  lag;
    logic                  cand;
    logic                  any_free;
    logic [IDX_BITS-1:0]   free_idx;

    assign rsp.valid     = out_valid_reg;
    assign rsp.kind      = out_kind_reg;
    assign rsp.fired_tag = out_tag_reg;
    assign rsp.last      = out_last_reg;
    assign can_load      = !out_valid_reg || rsp.ready;
    assign q_ctl.valid   = head_valid;
    assign q_ctl.pop     = pop;

    assign lag  = now_reg - slot_due_reg[idx_reg];
    assign cand = slot_valid_reg[idx_reg] && !lag[TIME_BITS-1]
                  && (!best_hit_reg || lag > best_lag_reg);

    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = IDX_BITS'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        start_tick = 1'b0;
        do_add     = 1'b0;
        take       = 1'b0;
        scan_step  = 1'b0;
        load       = 1'b0;
        load_kind  = KIND_FIRED;
        load_tag   = '0;
        load_last  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid && can_load)
                begin
                    pop = 1'b1;
                    if (head_data.is_tick)
                    begin
                        start_tick = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        load = 1'b1;
                        if (any_free)
                        begin
                            do_add    = 1'b1;
                            load_kind = KIND_ACCEPT;
                        end
                        else
                        begin
                            load_kind = KIND_REJECT;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                scan_step = 1'b1;
                if (idx_reg == IDX_BITS'(SLOTS - 1))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (best_hit_reg && n_reg != CNT_BITS'(MAX_RES))
                begin
                    if (!pend_reg || can_load)
                    begin
                        take       = 1'b1;
                        load       = pend_reg;
                        load_tag   = pend_tag_reg;
                        load_last  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
                else if (!pend_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (can_load)
                begin
                    load       = 1'b1;
                    load_tag   = pend_tag_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            best_hit_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (start_tick)
            begin
                now_reg      <= now_reg + 1'b1;
                n_reg        <= '0;
                pend_reg     <= 1'b0;
                idx_reg      <= '0;
                best_hit_reg <= 1'b0;
            end
            if (do_add)
            begin
                slot_valid_reg[free_idx] <= 1'b1;
            end
            if (scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (cand)
                begin
                    best_hit_reg <= 1'b1;
                end
            end
            if (take)
            begin
                pend_reg     <= 1'b1;
                n_reg        <= n_reg + 1'b1;
                idx_reg      <= '0;
                best_hit_reg <= 1'b0;
                if (!best_periodic_reg)
                begin
                    slot_valid_reg[best_idx_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (load)
        begin
            out_kind_reg <= load_kind;
            out_tag_reg  <= load_tag;
            out_last_reg <= load_last;
        end
        if (do_add)
        begin
            slot_due_reg[free_idx]      <= now_reg + TIME_BITS'(head_data.delay);
            slot_periodic_reg[free_idx] <= head_data.periodic;
            slot_period_reg[free_idx]   <= head_data.period;
            slot_tag_reg[free_idx]      <= head_data.tag;
        end
        if (scan_step && cand)
        begin
            best_lag_reg      <= lag;
            best_idx_reg      <= idx_reg;
            best_due_reg      <= slot_due_reg[idx_reg];
            best_periodic_reg <= slot_periodic_reg[idx_reg];
            best_period_reg   <= slot_period_reg[idx_reg];
            best_tag_reg      <= slot_tag_reg[idx_reg];
        end
        if (take)
        begin
            pend_tag_reg <= best_tag_reg;
            if (best_periodic_reg)
            begin
                slot_due_reg[best_idx_reg] <= best_due_reg + TIME_BITS'(best_period_reg);
            end
        end
    end

endmodule

// File: rtl/periodic_timer_event_scheduler.sv
// Top level of the periodic timer event scheduler: front end, command queue, back end.
// Depends on pte_pkg, pte_ifs, pte_front, pte_cmd_fifo, pte_back.
//
//   channel | dir | fields
//   cmd     | in  | op, delay, period, task_tag
//   rsp     | out | kind, fired_tag, last
//
// An add is handled in the back end once the response register is free.
// During a tick, each firing needs a full scan of the table, one slot per
// cycle, followed by the decide state.
// Reset empties the table at once; no clearing pass.
// The two-entry command queue keeps taking beats while a response stalls, until it is full.
module periodic_timer_event_scheduler
    import pte_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pte_cmd_if.sink   cmd,
    pte_rsp_if.source rsp
);

    logic   push;
    cmd_t   push_data;
    logic   q_full;
    q_ctl_t q_ctl;
    logic   head_valid;
    cmd_t   head_data;

    pte_front u_front (
        .cmd       (cmd),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    pte_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .ctl_in     (q_ctl),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    pte_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .q_ctl      (q_ctl),
        .rsp        (rsp)
    );

`ifndef NO_ASSERTIONS
    a_add_rsp_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.kind != KIND_FIRED |-> rsp.last && rsp.fired_tag == '0)
        else $error("add response must be last with zero tag");

    a_nonlast_fired: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.last |-> rsp.kind == KIND_FIRED)
        else $error("only fired beats may be non-last");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.kind != 2'd3)
        else $error("bad response kind");
`endif

endmodule
